// ----- src/csa_pkg.sv -----
// csa_pkg: shared types for the contiguous slot allocator.
// Command and status bundles between csa_ctrl and csa_dp. No dependencies.
package csa_pkg;

    localparam int unsigned OWNER_IN_W = 8;
    localparam int unsigned REQ_W      = 9;
    localparam int unsigned START_W    = 8;

    typedef struct packed {
        logic clr;   // write zero at sweep address, advance
        logic load;  // latch a new transaction
        logic scan;  // run the read sweep
        logic fill;  // write owner over the chosen run
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic owner_nz;
        logic req_ok;
        logic scan_end;
        logic found;
        logic fill_last;
    } t_sts;

endpackage

// ----- src/csa_ram.sv -----
// csa_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module csa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/csa_dp.sv -----
// csa_dp: slot owner memory, sweep counters, hole tracking and fit selection.
// Depends on csa_pkg and csa_ram.
module csa_dp
    import csa_pkg::*;
#(
    parameter int unsigned SLOTS    = 256,
    parameter int unsigned ID_WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  i_mode,
    input  logic [OWNER_IN_W-1:0] i_owner_id,
    input  logic [REQ_W-1:0]      i_request_slots,
    output logic                  o_success,
    output logic [START_W-1:0]    o_start_slot
);

    localparam int unsigned AW = $clog2(SLOTS);
    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

    logic                r_policy;
    logic                r_mode;
    logic [ID_WIDTH-1:0] r_owner;
    logic [CW-1:0]       r_need;
    logic [AW-1:0]       r_addr;
    logic                r_iss_done;
    logic                r_dv;
    logic                r_dlast;
    logic [AW-1:0]       r_didx;
    logic [CW-1:0]       r_hlen;
    logic [AW-1:0]       r_hstart;
    logic                r_found;
    logic [CW-1:0]       r_best_len;
    logic [AW-1:0]       r_best_pos;
    logic [CW-1:0]       r_left;
    logic                r_success;
    logic [START_W-1:0]  r_start;

    logic [ID_WIDTH-1:0] owner_m;
    logic [ID_WIDTH-1:0] rd_data;
    logic                rd_en;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [ID_WIDTH-1:0] wdata;
    logic                is_free;
    logic [CW-1:0]       len_eff;
    logic [AW-1:0]       start_eff;
    logic                cand;
    logic                take;
    logic                n_found;
    logic [AW-1:0]       n_pos;
    logic                scan_end;

    assign owner_m = ID_WIDTH'(i_owner_id);
    assign rd_en   = i_cmd.scan && !r_iss_done;

    csa_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    // hole tracking on returned data
    always_comb begin
        is_free   = (rd_data == '0);
        len_eff   = r_hlen + CW'(is_free);
        start_eff = (is_free && r_hlen == '0) ? r_didx : r_hstart;
        cand      = r_dv && (!is_free || r_dlast) && (len_eff >= r_need) && (len_eff != '0);
        take      = cand && (!r_found || (r_policy && len_eff < r_best_len));
        n_found   = r_found || cand;
        n_pos     = take ? start_eff : r_best_pos;
        scan_end  = r_dv && r_dlast;
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = '0;
        if (i_cmd.clr) begin
            we = 1'b1;
        end else if (i_cmd.fill) begin
            we    = 1'b1;
            wdata = r_owner;
        end else if (i_cmd.scan && r_mode) begin
            we    = r_dv && (rd_data == r_owner);
            waddr = r_didx;
        end
    end

    always_comb begin
        o_sts.clr_last  = (r_addr == LAST_ADDR);
        o_sts.owner_nz  = (owner_m != '0);
        o_sts.req_ok    = (owner_m != '0) && (i_request_slots != '0)
                          && (32'(i_request_slots) <= 32'(SLOTS));
        o_sts.scan_end  = scan_end;
        o_sts.found     = n_found;
        o_sts.fill_last = (r_left == CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= 1'b0;
            r_addr     <= '0;
            r_iss_done <= 1'b0;
            r_dv       <= 1'b0;
            r_success  <= 1'b0;
            r_start    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            r_dv <= rd_en;
            if (i_cmd.load) begin
                r_addr     <= '0;
                r_iss_done <= 1'b0;
                r_success  <= i_mode;
                r_start    <= '0;
            end else if (i_cmd.clr || i_cmd.fill) begin
                r_addr <= r_addr + AW'(1);
            end else if (rd_en) begin
                r_addr     <= r_addr + AW'(1);
                r_iss_done <= (r_addr == LAST_ADDR);
            end else if (i_cmd.scan && scan_end && !r_mode) begin
                r_addr    <= n_pos;
                r_success <= n_found;
                r_start   <= n_found ? START_W'(n_pos) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx  <= r_addr;
        r_dlast <= (r_addr == LAST_ADDR);
        if (i_cmd.load) begin
            r_mode     <= i_mode;
            r_owner    <= owner_m;
            r_need     <= CW'(i_request_slots);
            r_hlen     <= '0;
            r_hstart   <= '0;
            r_found    <= 1'b0;
            r_best_len <= '0;
            r_best_pos <= '0;
        end else if (r_dv) begin
            r_hlen     <= is_free ? len_eff : '0;
            r_hstart   <= start_eff;
            r_found    <= n_found;
            r_best_pos <= n_pos;
            if (take) begin
                r_best_len <= len_eff;
            end
        end
        if (i_cmd.scan && scan_end) begin
            r_left <= r_need;
        end else if (i_cmd.fill) begin
            r_left <= r_left - CW'(1);
        end
    end

    assign o_success    = r_success;
    assign o_start_slot = r_start;

endmodule

// ----- src/csa_ctrl.sv -----
// csa_ctrl: sequencer for clear, scan, fill and response phases.
// Depends on csa_pkg.
module csa_ctrl
    import csa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic i_mode,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy,
    output logic o_done
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FILL = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_mode) begin
                        n_state = i_sts.owner_nz ? S_SCAN : S_RESP;
                    end else begin
                        n_state = i_sts.req_ok ? S_SCAN : S_RESP;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = (!i_mode && i_sts.found) ? S_FILL : S_RESP;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_RESP);

endmodule

// ----- src/contiguous_slot_allocator.sv -----
// Contiguous slot allocator top level, first fit or best fit per i_cfg_wdata.
// Reset selects first fit and runs a clearing pass over all slots with busy high.
// A placed allocate runs the scan, fill and response phases, a free or an allocate
// with no fit the scan and response, a rejected request or a free of owner zero only
// the response. Next accept in the cycle after o_done; the receiver cannot stall.
// Depends on csa_pkg, csa_ctrl, csa_dp, csa_ram.
module contiguous_slot_allocator
    import csa_pkg::*;
#(
    parameter int unsigned SLOTS    = 256,
    parameter int unsigned ID_WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_mode,
    input  logic [OWNER_IN_W-1:0] i_owner_id,
    input  logic [REQ_W-1:0]      i_request_slots,
    output logic                  o_done,
    output logic                  o_success,
    output logic [START_W-1:0]    o_start_slot
);

    t_cmd cmd;
    t_sts sts;
    logic mode_q;

    // mode seen by the controller: live on accept, latched afterwards
    logic r_mode;
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_mode <= i_mode;
        end
    end
    assign mode_q = busy ? r_mode : i_mode;

    csa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (mode_q),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    csa_dp #(
        .SLOTS    (SLOTS),
        .ID_WIDTH (ID_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_mode          (i_mode),
        .i_owner_id      (i_owner_id),
        .i_request_slots (i_request_slots),
        .o_success       (o_success),
        .o_start_slot    (o_start_slot)
    );

endmodule
